### src/fixed_drop_mailer_scanner_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-drop mailer scanner
// Clocked, reset-qualified concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef FIXED_DROP_MAILER_SCANNER_MACROS_SVH
`define FIXED_DROP_MAILER_SCANNER_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define FDMS_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fdms assertion failed");

// Assertion on the block clock and reset
`define FDMS_ASSERT(label, prop) \
  `FDMS_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

### src/fdms_pkg.sv
// ---------------------------------------------------------------------------
// fdms_pkg
// Widths, codes and character-class helpers of the mailer scanner.
// ---------------------------------------------------------------------------
package fdms_pkg;

  // Offset counter width; reported offsets are its low 32 bits
  localparam int unsigned OFFSET_BITS  = 32;
  localparam int unsigned OFF_REPORT_W = 32;

  // Stream payload layout
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_FIELDS_W = 1 + 2 * OFF_REPORT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_MAIL_LSB = 1;
  localparam int unsigned OUT_ADDR_LSB = 1 + OFF_REPORT_W;

  // Characters
  localparam logic [7:0] CH_M      = 8'h6d;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // Class of the previous byte
  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_QUOTE  = 2'd1,
    CLS_IDENT  = 2'd2,
    CLS_LOCALX = 2'd3
  } byte_cls_e;

  // Mail call recognizer
  typedef enum logic [4:0] {
    MAIL_IDLE = 5'b00001,
    MAIL_M    = 5'b00010,
    MAIL_MA   = 5'b00100,
    MAIL_MAI  = 5'b01000,
    MAIL_MAIL = 5'b10000
  } mail_state_e;

  // Field read recognizer
  typedef enum logic [3:0] {
    FLD_IDLE   = 4'b0001,
    FLD_DOLLAR = 4'b0010,
    FLD_NAME   = 4'b0100,
    FLD_AFTER  = 4'b1000
  } fld_state_e;

  // Field name candidates
  localparam int unsigned NM_POST    = 0;
  localparam int unsigned NM_REQUEST = 1;

  // Domain tracking flag bits
  localparam int unsigned DF_NONEMPTY  = 0;
  localparam int unsigned DF_HAS_DOT   = 1;
  localparam int unsigned DF_DOT_LATE  = 2;
  localparam int unsigned DF_TLD_ALPHA = 3;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return is_alnum(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_quote(logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  function automatic logic is_local(logic [7:0] b);
    return is_alnum(b) || (b == CH_DOT) || (b == CH_UNDER) || (b == CH_PCT) ||
           (b == CH_PLUS) || (b == CH_DASH);
  endfunction

  function automatic logic is_domain(logic [7:0] b);
    return is_alnum(b) || (b == CH_DOT) || (b == CH_DASH);
  endfunction

  function automatic logic [7:0] lower_of(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? 8'(b + 8'd32) : b;
  endfunction

  function automatic byte_cls_e class_of(logic [7:0] b);
    if (is_quote(b)) return CLS_QUOTE;
    if (is_ident(b)) return CLS_IDENT;
    if (is_local(b)) return CLS_LOCALX;
    return CLS_OTHER;
  endfunction

  // "post", one letter per index
  function automatic logic [7:0] post_char(logic [1:0] n);
    logic [7:0] c;
    case (n)
      2'd0:    c = 8'h70;
      2'd1:    c = 8'h6f;
      2'd2:    c = 8'h73;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // "request", one letter per index; index seven never compares
  function automatic logic [7:0] request_char(logic [2:0] n);
    logic [7:0] c;
    case (n)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h71;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h73;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/fixed_drop_mailer_scanner.sv
// ---------------------------------------------------------------------------
// fixed_drop_mailer_scanner
// Byte-stream scanner for a mail call, a post/request field read and a
// quoted address, reporting once per file.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis carries one file byte per transaction in tdata[7:0]; tlast marks
//    the final byte of the file.
//  - m_axis carries one result per file, on the last byte only: tdata holds
//    match_found, mail_offset and address_offset.
//  - Throughput: one byte per cycle, except while a tlast byte waits for
//    the output register. A byte is captured in an input register and the
//    three recognizers update their state from it.
//  - Two register stages; the tlast byte sets m_axis_tvalid when processed.
//  - When m_axis stalls, the result is held in the output register; bytes
//    keep flowing until the next tlast byte reaches the input register,
//    which then waits for the output register to free up.
//  - After a tlast byte all scanner state returns to its reset values, so
//    the next byte starts a new file.
//  - Reset (rst_ni low) clears the byte counter, all recognizers and both
//    valid flags; no result is pending afterwards.
//  - The byte offset counter saturates at its maximum value.
// ---------------------------------------------------------------------------
module fixed_drop_mailer_scanner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fields: data_byte[7:0]
  input  logic [fdms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields: match_found[0], mail_offset[32:1], address_offset[64:33], zeros
  output logic [fdms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);
  import fdms_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // Input register
  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  logic                  proc;

  // Output register
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Scanner state
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  byte_cls_e              prev_cls_q, prev_cls_d;
  mail_state_e            mail_state_q, mail_state_d;
  logic [OFFSET_BITS-1:0] mail_cand_q, mail_cand_d;
  logic                   mail_seen_q, mail_seen_d;
  logic [OFFSET_BITS-1:0] mail_first_q, mail_first_d;
  fld_state_e             fld_state_q, fld_state_d;
  logic [3:0]             fld_len_q, fld_len_d;
  logic [1:0]             fld_match_q, fld_match_d;
  logic                   fld_seen_q, fld_seen_d;
  logic                   lrun_quoted_q, lrun_quoted_d;
  logic [OFFSET_BITS-1:0] lrun_qoff_q, lrun_qoff_d;
  logic                   dom_act_q, dom_act_d;
  logic [OFFSET_BITS-1:0] cand_qoff_q, cand_qoff_d;
  logic [3:0]             dom_flags_q, dom_flags_d;
  logic [1:0]             tld_len_q, tld_len_d;
  logic                   addr_seen_q, addr_seen_d;
  logic [OFFSET_BITS-1:0] addr_first_q, addr_first_d;

  // Per-byte helpers
  logic [7:0]  lc;
  logic        mail_restart;
  fld_state_e  fld_fresh;
  logic        name_ok;
  logic        prev_local;
  logic        addr_ok;

  // Handshake: a tlast byte waits for a free output register
  assign proc          = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Capture register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_last_q <= s_axis_tlast;
    end
  end

  // Mail call recognizer
  always_comb begin
    lc           = lower_of(in_byte_q);
    mail_restart = (lc == CH_M) && (prev_cls_q != CLS_IDENT);
    mail_state_d = mail_state_q;
    mail_cand_d  = mail_cand_q;
    mail_seen_d  = mail_seen_q;
    mail_first_d = mail_first_q;
    case (mail_state_q)
      MAIL_M: begin
        if (lc == CH_A) begin
          mail_state_d = MAIL_MA;
        end else begin
          mail_state_d = mail_restart ? MAIL_M : MAIL_IDLE;
          if (mail_restart) mail_cand_d = pos_q;
        end
      end
      MAIL_MA: begin
        if (lc == CH_I) begin
          mail_state_d = MAIL_MAI;
        end else begin
          mail_state_d = mail_restart ? MAIL_M : MAIL_IDLE;
          if (mail_restart) mail_cand_d = pos_q;
        end
      end
      MAIL_MAI: begin
        if (lc == CH_L) begin
          mail_state_d = MAIL_MAIL;
        end else begin
          mail_state_d = mail_restart ? MAIL_M : MAIL_IDLE;
          if (mail_restart) mail_cand_d = pos_q;
        end
      end
      MAIL_MAIL: begin
        if (is_blank(in_byte_q)) begin
          mail_state_d = MAIL_MAIL;
        end else if (in_byte_q == CH_LPAREN) begin
          if (!mail_seen_q) begin
            mail_seen_d  = 1'b1;
            mail_first_d = mail_cand_q;
          end
          mail_state_d = MAIL_IDLE;
        end else begin
          mail_state_d = mail_restart ? MAIL_M : MAIL_IDLE;
          if (mail_restart) mail_cand_d = pos_q;
        end
      end
      default: begin
        mail_state_d = mail_restart ? MAIL_M : MAIL_IDLE;
        if (mail_restart) mail_cand_d = pos_q;
      end
    endcase
  end

  // Field read recognizer
  always_comb begin
    fld_fresh   = (in_byte_q == CH_DOLLAR) ? FLD_DOLLAR : FLD_IDLE;
    name_ok     = (fld_match_q[NM_POST] && (fld_len_q == 4'd4)) ||
                  (fld_match_q[NM_REQUEST] && (fld_len_q == 4'd7));
    fld_state_d = fld_state_q;
    fld_len_d   = fld_len_q;
    fld_match_d = fld_match_q;
    fld_seen_d  = fld_seen_q;
    case (fld_state_q)
      FLD_NAME: begin
        if (is_ident(in_byte_q)) begin
          if (fld_len_q >= 4'd4 || post_char(fld_len_q[1:0]) != lc) begin
            fld_match_d[NM_POST] = 1'b0;
          end
          if (fld_len_q >= 4'd7 || request_char(fld_len_q[2:0]) != lc) begin
            fld_match_d[NM_REQUEST] = 1'b0;
          end
          if (fld_len_q != 4'd15) fld_len_d = 4'(fld_len_q + 4'd1);
        end else if (name_ok && is_blank(in_byte_q)) begin
          fld_state_d = FLD_AFTER;
        end else if (name_ok && in_byte_q == CH_LBRACK) begin
          fld_seen_d  = 1'b1;
          fld_state_d = FLD_IDLE;
        end else begin
          fld_state_d = fld_fresh;
        end
      end
      FLD_AFTER: begin
        if (is_blank(in_byte_q)) begin
          fld_state_d = FLD_AFTER;
        end else if (in_byte_q == CH_LBRACK) begin
          fld_seen_d  = 1'b1;
          fld_state_d = FLD_IDLE;
        end else begin
          fld_state_d = fld_fresh;
        end
      end
      FLD_DOLLAR: begin
        if (in_byte_q == CH_UNDER) begin
          fld_state_d = FLD_NAME;
          fld_len_d   = 4'd0;
          fld_match_d = 2'b11;
        end else begin
          fld_state_d = fld_fresh;
        end
      end
      default: fld_state_d = fld_fresh;
    endcase
  end

  // Quoted address recognizer
  always_comb begin
    prev_local    = (prev_cls_q == CLS_IDENT) || (prev_cls_q == CLS_LOCALX);
    addr_ok       = is_quote(in_byte_q) && dom_flags_q[DF_HAS_DOT] &&
                    dom_flags_q[DF_DOT_LATE] && dom_flags_q[DF_TLD_ALPHA] &&
                    (tld_len_q >= 2'd2);
    dom_act_d     = dom_act_q;
    dom_flags_d   = dom_flags_q;
    tld_len_d     = tld_len_q;
    addr_seen_d   = addr_seen_q;
    addr_first_d  = addr_first_q;
    lrun_quoted_d = lrun_quoted_q;
    lrun_qoff_d   = lrun_qoff_q;
    cand_qoff_d   = cand_qoff_q;

    // domain part
    if (dom_act_q) begin
      if (is_domain(in_byte_q)) begin
        if (in_byte_q == CH_DOT) begin
          dom_flags_d               = '0;
          dom_flags_d[DF_DOT_LATE]  = dom_flags_q[DF_NONEMPTY];
          dom_flags_d[DF_HAS_DOT]   = 1'b1;
          dom_flags_d[DF_TLD_ALPHA] = 1'b1;
          tld_len_d                 = 2'd0;
        end else begin
          if (!is_alpha(in_byte_q)) dom_flags_d[DF_TLD_ALPHA] = 1'b0;
          if (tld_len_q != 2'd3) tld_len_d = 2'(tld_len_q + 2'd1);
        end
        dom_flags_d[DF_NONEMPTY] = 1'b1;
      end else begin
        if (addr_ok && !addr_seen_q) begin
          addr_seen_d  = 1'b1;
          addr_first_d = cand_qoff_q;
        end
        dom_act_d = 1'b0;
      end
    end

    // local part tracking
    if (is_quote(in_byte_q)) lrun_qoff_d = pos_q;
    if (is_local(in_byte_q) && !prev_local) lrun_quoted_d = (prev_cls_q == CLS_QUOTE);

    // '@' after a quoted local run opens a domain
    if (in_byte_q == CH_AT && prev_local && lrun_quoted_q) begin
      dom_act_d   = 1'b1;
      cand_qoff_d = lrun_qoff_q;
      dom_flags_d = '0;
      tld_len_d   = 2'd0;
    end
  end

  // Byte class and saturating offset
  assign prev_cls_d = class_of(in_byte_q);
  assign pos_d      = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

  // Scanner state registers; tlast returns them to reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      prev_cls_q    <= CLS_OTHER;
      mail_state_q  <= MAIL_IDLE;
      mail_cand_q   <= '0;
      mail_seen_q   <= 1'b0;
      mail_first_q  <= '0;
      fld_state_q   <= FLD_IDLE;
      fld_len_q     <= '0;
      fld_match_q   <= 2'b11;
      fld_seen_q    <= 1'b0;
      lrun_quoted_q <= 1'b0;
      lrun_qoff_q   <= '0;
      dom_act_q     <= 1'b0;
      cand_qoff_q   <= '0;
      dom_flags_q   <= '0;
      tld_len_q     <= '0;
      addr_seen_q   <= 1'b0;
      addr_first_q  <= '0;
    end else if (proc) begin
      if (in_last_q) begin
        pos_q         <= '0;
        prev_cls_q    <= CLS_OTHER;
        mail_state_q  <= MAIL_IDLE;
        mail_cand_q   <= '0;
        mail_seen_q   <= 1'b0;
        mail_first_q  <= '0;
        fld_state_q   <= FLD_IDLE;
        fld_len_q     <= '0;
        fld_match_q   <= 2'b11;
        fld_seen_q    <= 1'b0;
        lrun_quoted_q <= 1'b0;
        lrun_qoff_q   <= '0;
        dom_act_q     <= 1'b0;
        cand_qoff_q   <= '0;
        dom_flags_q   <= '0;
        tld_len_q     <= '0;
        addr_seen_q   <= 1'b0;
        addr_first_q  <= '0;
      end else begin
        pos_q         <= pos_d;
        prev_cls_q    <= prev_cls_d;
        mail_state_q  <= mail_state_d;
        mail_cand_q   <= mail_cand_d;
        mail_seen_q   <= mail_seen_d;
        mail_first_q  <= mail_first_d;
        fld_state_q   <= fld_state_d;
        fld_len_q     <= fld_len_d;
        fld_match_q   <= fld_match_d;
        fld_seen_q    <= fld_seen_d;
        lrun_quoted_q <= lrun_quoted_d;
        lrun_qoff_q   <= lrun_qoff_d;
        dom_act_q     <= dom_act_d;
        cand_qoff_q   <= cand_qoff_d;
        dom_flags_q   <= dom_flags_d;
        tld_len_q     <= tld_len_d;
        addr_seen_q   <= addr_seen_d;
        addr_first_q  <= addr_first_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result fields packed from the final state of the file
  always_comb begin
    out_data_d    = '0;
    out_data_d[0] = mail_seen_d && fld_seen_d && addr_seen_d;
    out_data_d[OUT_MAIL_LSB +: OFF_REPORT_W] =
      mail_seen_d ? OFF_REPORT_W'(mail_first_d) : '0;
    out_data_d[OUT_ADDR_LSB +: OFF_REPORT_W] =
      addr_seen_d ? OFF_REPORT_W'(addr_first_d) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

### src/fdms_checker.sv
// ---------------------------------------------------------------------------
// fdms_checker
// Port-level checks of the mailer scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "fixed_drop_mailer_scanner_macros.svh"

module fdms_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tlast,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [fdms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);
  import fdms_pkg::*;

  logic in_xact;
  logic pad_zero;

  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign pad_zero = (m_axis_tdata >> OUT_FIELDS_W) == '0;

  // A stalled result holds its value
  `FDMS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // A new result follows a tlast transaction on the input
  `FDMS_ASSERT(a_out_after_last, $rose(m_axis_tvalid) |-> $past(in_xact && s_axis_tlast, 2))

  // With no result pending, input is never back-pressured
  `FDMS_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)

  // Padding bits above the result fields stay zero
  `FDMS_ASSERT(a_pad_zero, m_axis_tvalid |-> pad_zero)

endmodule

bind fixed_drop_mailer_scanner fdms_checker u_fdms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
